>>> sv/avlr_pkg.sv
// Shared types, constants and helpers for the AVC-LAN frame receiver.
`timescale 1ns / 1ps

package avlr_pkg;

    localparam int TICK_WIDTH_DEFAULT = 8;
    localparam int ADDR_W             = 12;
    localparam int THRESH_W           = 8;
    localparam int VALUE_W            = 12;
    localparam int INDEX_W            = 8;
    localparam int COUNT_W            = 4;
    localparam int CFG_INDEX_W        = 1;
    localparam int CFG_DATA_W         = 12;

    localparam logic [ADDR_W-1:0]   OWN_ADDRESS_RESET   = 12'd0;
    localparam logic [THRESH_W-1:0] BIT_THRESHOLD_RESET = 8'd26;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_THRESHOLD = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_BCAST       = 4'd1,
        PH_MASTER      = 4'd2,
        PH_SLAVE       = 4'd3,
        PH_ACK_SLAVE   = 4'd4,
        PH_CONTROL     = 4'd5,
        PH_ACK_CONTROL = 4'd6,
        PH_LENGTH      = 4'd7,
        PH_ACK_LENGTH  = 4'd8,
        PH_DATA        = 4'd9,
        PH_ACK_DATA    = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        KIND_BCAST   = 3'd0,
        KIND_MASTER  = 3'd1,
        KIND_SLAVE   = 3'd2,
        KIND_CONTROL = 3'd3,
        KIND_LENGTH  = 3'd4,
        KIND_DATA    = 3'd5,
        KIND_ACK     = 3'd6
    } field_kind_t;

    typedef struct packed {
        field_kind_t          field_kind;
        logic [VALUE_W-1:0]   field_value;
        logic [INDEX_W-1:0]   byte_index;
        logic                 parity_bad;
        logic                 addressed_to_me;
        logic                 drive_ack;
        logic                 frame_last;
    } result_t;

    // Number of data bits in the field collected during a phase
    function automatic logic [COUNT_W-1:0] field_width(input phase_t ph);
        logic [COUNT_W-1:0] w;
        case (ph)
            PH_MASTER, PH_SLAVE: w = 4'd12;
            PH_CONTROL:          w = 4'd4;
            PH_LENGTH, PH_DATA:  w = 4'd8;
            default:             w = 4'd1;
        endcase
        return w;
    endfunction

endpackage

>>> sv/avlr_if.sv
// Handshake interfaces for the pulse input channel and the field result channel.
`timescale 1ns / 1ps

interface avlr_pulse_if
    import avlr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [TICK_WIDTH-1:0] pulse_ticks;
    logic                  begin_frame;

    modport source (output valid, output pulse_ticks, output begin_frame, input ready);
    modport sink   (input valid, input pulse_ticks, input begin_frame, output ready);
endinterface

interface avlr_field_if
    import avlr_pkg::*;
;
    logic               valid;
    logic               ready;
    field_kind_t        field_kind;
    logic [VALUE_W-1:0] field_value;
    logic [INDEX_W-1:0] byte_index;
    logic               parity_bad;
    logic               addressed_to_me;
    logic               drive_ack;
    logic               frame_last;

    modport source (
        output valid, output field_kind, output field_value, output byte_index,
        output parity_bad, output addressed_to_me, output drive_ack, output frame_last,
        input ready
    );
    modport sink (
        input valid, input field_kind, input field_value, input byte_index,
        input parity_bad, input addressed_to_me, input drive_ack, input frame_last,
        output ready
    );
endinterface

>>> sv/avlr_frame_fsm.sv
// Frame state machine: bit decode, field assembly, parity and ack slot handling.
`timescale 1ns / 1ps

module avlr_frame_fsm
    import avlr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [TICK_WIDTH-1:0] pulse_ticks,
    input  logic                  begin_frame,
    input  logic [ADDR_W-1:0]     own_address,
    input  logic [THRESH_W-1:0]   bit_threshold,
    output logic                  emit,
    output result_t               result
);

    localparam int CMP_W = (TICK_WIDTH > THRESH_W) ? TICK_WIDTH : THRESH_W;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [VALUE_W-1:0] shift_value_reg, shift_value_next;
    logic               parity_reg, parity_next;
    logic               for_me_reg, for_me_next;
    logic [INDEX_W-1:0] payload_length_reg, payload_length_next;
    logic [INDEX_W-1:0] bytes_seen_reg, bytes_seen_next;

    logic [CMP_W-1:0]   ticks_ext;
    logic [CMP_W-1:0]   thresh_ext;
    logic               bit_value;
    logic               bad;
    logic [INDEX_W-1:0] bytes_inc;

    assign ticks_ext  = CMP_W'(pulse_ticks);
    assign thresh_ext = CMP_W'(bit_threshold);
    assign bit_value  = (ticks_ext < thresh_ext);
    assign bad        = (bit_value != parity_reg);
    assign bytes_inc  = bytes_seen_reg + INDEX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            bit_count_reg      <= '0;
            shift_value_reg    <= '0;
            parity_reg         <= 1'b0;
            for_me_reg         <= 1'b0;
            payload_length_reg <= '0;
            bytes_seen_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            bit_count_reg      <= bit_count_next;
            shift_value_reg    <= shift_value_next;
            parity_reg         <= parity_next;
            for_me_reg         <= for_me_next;
            payload_length_reg <= payload_length_next;
            bytes_seen_reg     <= bytes_seen_next;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        bit_count_next      = bit_count_reg;
        shift_value_next    = shift_value_reg;
        parity_next         = parity_reg;
        for_me_next         = for_me_reg;
        payload_length_next = payload_length_reg;
        bytes_seen_next     = bytes_seen_reg;
        emit                = 1'b0;
        result              = '0;
        result.field_kind   = KIND_BCAST;

        if (begin_frame)
        begin
            phase_next          = PH_BCAST;
            bit_count_next      = '0;
            shift_value_next    = '0;
            parity_next         = 1'b0;
            for_me_next         = 1'b0;
            payload_length_next = '0;
            bytes_seen_next     = '0;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                end
                PH_BCAST:
                begin
                    emit               = 1'b1;
                    result.field_kind  = KIND_BCAST;
                    result.field_value = VALUE_W'(bit_value);
                    phase_next         = PH_MASTER;
                    bit_count_next     = '0;
                    shift_value_next   = '0;
                    parity_next        = 1'b0;
                end
                PH_MASTER, PH_SLAVE, PH_CONTROL, PH_LENGTH, PH_DATA:
                begin
                    if (bit_count_reg < field_width(phase_reg))
                    begin
                        shift_value_next = {shift_value_reg[VALUE_W-2:0], bit_value};
                        parity_next      = parity_reg ^ bit_value;
                        bit_count_next   = bit_count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        emit               = 1'b1;
                        result.field_value = shift_value_reg;
                        result.parity_bad  = bad;
                        result.frame_last  = bad;
                        bit_count_next     = '0;
                        shift_value_next   = '0;
                        parity_next        = 1'b0;
                        case (phase_reg)
                            PH_MASTER:
                            begin
                                result.field_kind = KIND_MASTER;
                                phase_next        = PH_SLAVE;
                            end
                            PH_SLAVE:
                            begin
                                result.field_kind = KIND_SLAVE;
                                for_me_next       = (shift_value_reg == own_address);
                                phase_next        = PH_ACK_SLAVE;
                            end
                            PH_CONTROL:
                            begin
                                result.field_kind = KIND_CONTROL;
                                phase_next        = PH_ACK_CONTROL;
                            end
                            PH_LENGTH:
                            begin
                                result.field_kind   = KIND_LENGTH;
                                payload_length_next = shift_value_reg[INDEX_W-1:0];
                                phase_next          = PH_ACK_LENGTH;
                            end
                            default:
                            begin
                                result.field_kind = KIND_DATA;
                                result.byte_index = bytes_seen_reg;
                                phase_next        = PH_ACK_DATA;
                            end
                        endcase
                        if (bad)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_ACK_SLAVE, PH_ACK_CONTROL, PH_ACK_LENGTH, PH_ACK_DATA:
                begin
                    emit              = 1'b1;
                    result.field_kind = KIND_ACK;
                    result.drive_ack  = for_me_reg;
                    bit_count_next    = '0;
                    shift_value_next  = '0;
                    parity_next       = 1'b0;
                    case (phase_reg)
                        PH_ACK_SLAVE:   phase_next = PH_CONTROL;
                        PH_ACK_CONTROL: phase_next = PH_LENGTH;
                        PH_ACK_LENGTH:
                        begin
                            if (payload_length_reg == '0)
                            begin
                                result.frame_last = 1'b1;
                                phase_next        = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        default:
                        begin
                            bytes_seen_next = bytes_inc;
                            if (bytes_inc >= payload_length_reg)
                            begin
                                result.frame_last = 1'b1;
                                phase_next        = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // The slave field updates the match flag in the same word it reports
        result.addressed_to_me = for_me_next;
    end

endmodule

>>> sv/avc_lan_frame_receiver_unit.sv
// Top level of the AVC-LAN frame receiver: config registers, frame logic, output buffer.
`timescale 1ns / 1ps

// AVC-LAN frame receiver. Feed one word per bit pulse on pulse_in: the measured
// high time in ticks, with begin_frame set on the start bit. A pulse shorter than
// bit_threshold is a 1. The block returns one word on field_out for each
// completed field (with its parity check), for the broadcast bit, and for every
// ack slot; drive_ack asks for the ack to be pulled low when the slave address
// matched own_address. A start bit or a field bit that does not close a field
// returns nothing. Throughput is one pulse per clock while the skid entry is free:
// the whole decode is a single pass through the frame state machine, and a result
// is registered in the output register, or in the skid register on a stall. A
// two-entry output buffer (output register plus skid register) keeps pulse_in
// ready until the skid entry fills; pulse_in.ready drops only while both hold
// words. There is no start-up sweep: the block takes pulses right after reset.
// Write own_address and bit_threshold only while no frame result is pending.
module avc_lan_frame_receiver_unit
    import avlr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    avlr_pulse_if.sink             pulse_in,
    avlr_field_if.source           field_out,
    input  logic                   write_en,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data
);

    logic [ADDR_W-1:0]   own_address_reg;
    logic [THRESH_W-1:0] bit_threshold_reg;

    logic    step;
    logic    emit;
    result_t result;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= OWN_ADDRESS_RESET;
            bit_threshold_reg <= BIT_THRESHOLD_RESET;
        end
        else if (write_en)
        begin
            unique case (write_index)
                REG_OWN_ADDRESS:   own_address_reg   <= write_data[ADDR_W-1:0];
                REG_BIT_THRESHOLD: bit_threshold_reg <= write_data[THRESH_W-1:0];
            endcase
        end
    end

    // Accept a pulse whenever the skid entry is free
    assign pulse_in.ready = !skid_valid_reg;
    assign step           = pulse_in.valid && pulse_in.ready;

    avlr_frame_fsm #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_frame_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .pulse_ticks   (pulse_in.pulse_ticks),
        .begin_frame   (pulse_in.begin_frame),
        .own_address   (own_address_reg),
        .bit_threshold (bit_threshold_reg),
        .emit          (emit),
        .result        (result)
    );

    assign push = step && emit;
    assign pop  = out_valid_reg && field_out.ready;

    // Output buffer control: advance the skid word when the output drains,
    // park a new word in the skid entry while the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (out_valid_reg && !pop && push)
        begin
            skid_reg <= result;
        end
    end

    assign field_out.valid           = out_valid_reg;
    assign field_out.field_kind      = out_reg.field_kind;
    assign field_out.field_value     = out_reg.field_value;
    assign field_out.byte_index      = out_reg.byte_index;
    assign field_out.parity_bad      = out_reg.parity_bad;
    assign field_out.addressed_to_me = out_reg.addressed_to_me;
    assign field_out.drive_ack       = out_reg.drive_ack;
    assign field_out.frame_last      = out_reg.frame_last;

endmodule

>>> sv/avlr_checker.sv
// Port-level assertions for the AVC-LAN frame receiver, bound to the top level.
`timescale 1ns / 1ps

module avlr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  field_kind,
    input logic [11:0] field_value,
    input logic [7:0]  byte_index,
    input logic        parity_bad,
    input logic        drive_ack,
    input logic        frame_last
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_kind)
            && $stable(field_value) && $stable(byte_index) && $stable(frame_last))
        else $error("stalled result word changed");

    // Input back-pressure only with a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input not ready with empty output");

    // Input ready drops only after a stalled output cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input ready dropped without output stall");

    // A parity error closes the frame and never asks for an ack
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parity_bad |-> frame_last && !drive_ack)
        else $error("parity error word malformed");

endmodule

bind avc_lan_frame_receiver_unit avlr_checker u_avlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pulse_in.ready),
    .out_valid   (field_out.valid),
    .out_ready   (field_out.ready),
    .field_kind  (field_out.field_kind),
    .field_value (field_out.field_value),
    .byte_index  (field_out.byte_index),
    .parity_bad  (field_out.parity_bad),
    .drive_ack   (field_out.drive_ack),
    .frame_last  (field_out.frame_last)
);

>>> sim/avlr_field_monitor.sv
// Monitor that predicts the field words of the AVC-LAN frame receiver and checks them.
`timescale 1ns / 1ps

module avlr_field_monitor
    import avlr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    avlr_pulse_if                  pulse_mon,
    avlr_field_if                  field_mon,
    input  logic                   write_en,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [CFG_DATA_W-1:0]  write_data,
    output int unsigned            words_pending,
    output int unsigned            mismatch_count
);

    logic [ADDR_W-1:0]   own_addr;
    logic [THRESH_W-1:0] threshold;

    phase_t              frame_phase;
    logic [COUNT_W-1:0]  bits_taken;
    logic [VALUE_W-1:0]  field_shift;
    logic                field_parity;
    logic                slave_match;
    logic [INDEX_W-1:0]  payload_len;
    logic [INDEX_W-1:0]  bytes_done;

    result_t             expected_fields[$];
    int unsigned         mismatches;

    function automatic int field_bits(input phase_t ph);
        case (ph)
            PH_MASTER, PH_SLAVE: return ADDR_W;
            PH_CONTROL:          return 4;
            PH_LENGTH, PH_DATA:  return INDEX_W;
            default:             return 1;
        endcase
    endfunction

    function automatic void restart_field();
        bits_taken   = '0;
        field_shift  = '0;
        field_parity = 1'b0;
    endfunction

    // Advance the frame by one pulse; return 1 with the word the pulse produces.
    function automatic bit decode_pulse(input logic [TICK_WIDTH-1:0] ticks, input logic start,
                                        output result_t word);
        logic   one;
        logic   bad;
        bit     made;
        phase_t next_phase;
        one        = (ticks < threshold);
        word       = '0;
        made       = 1'b0;
        next_phase = PH_IDLE;
        if (start) begin
            frame_phase = PH_BCAST;
            restart_field();
            slave_match = 1'b0;
            payload_len = '0;
            bytes_done  = '0;
            return 1'b0;
        end
        case (frame_phase)
            PH_BCAST: begin
                word.field_kind  = KIND_BCAST;
                word.field_value = VALUE_W'(one);
                frame_phase      = PH_MASTER;
                restart_field();
                made = 1'b1;
            end
            PH_MASTER, PH_SLAVE, PH_CONTROL, PH_LENGTH, PH_DATA: begin
                if (int'(bits_taken) < field_bits(frame_phase)) begin
                    field_shift  = {field_shift[VALUE_W-2:0], one};
                    field_parity = field_parity ^ one;
                    bits_taken   = bits_taken + 1'b1;
                end
                else begin
                    bad              = (one != field_parity);
                    word.field_value = field_shift;
                    word.parity_bad  = bad;
                    word.frame_last  = bad;
                    case (frame_phase)
                        PH_MASTER: begin
                            word.field_kind = KIND_MASTER;
                            next_phase      = PH_SLAVE;
                        end
                        PH_SLAVE: begin
                            word.field_kind = KIND_SLAVE;
                            slave_match     = (field_shift == own_addr);
                            next_phase      = PH_ACK_SLAVE;
                        end
                        PH_CONTROL: begin
                            word.field_kind = KIND_CONTROL;
                            next_phase      = PH_ACK_CONTROL;
                        end
                        PH_LENGTH: begin
                            word.field_kind = KIND_LENGTH;
                            payload_len     = field_shift[INDEX_W-1:0];
                            next_phase      = PH_ACK_LENGTH;
                        end
                        default: begin
                            word.field_kind = KIND_DATA;
                            word.byte_index = bytes_done;
                            next_phase      = PH_ACK_DATA;
                        end
                    endcase
                    restart_field();
                    if (bad)
                        frame_phase = PH_IDLE;
                    else
                        frame_phase = next_phase;
                    made = 1'b1;
                end
            end
            PH_ACK_SLAVE, PH_ACK_CONTROL: begin
                word.field_kind = KIND_ACK;
                word.drive_ack  = slave_match;
                if (frame_phase == PH_ACK_SLAVE)
                    frame_phase = PH_CONTROL;
                else
                    frame_phase = PH_LENGTH;
                restart_field();
                made = 1'b1;
            end
            PH_ACK_LENGTH, PH_ACK_DATA: begin
                if (frame_phase == PH_ACK_DATA)
                    bytes_done = bytes_done + 1'b1;
                word.field_kind = KIND_ACK;
                word.drive_ack  = slave_match;
                word.frame_last = (bytes_done >= payload_len);
                if (word.frame_last)
                    frame_phase = PH_IDLE;
                else
                    frame_phase = PH_DATA;
                restart_field();
                made = 1'b1;
            end
            default: frame_phase = PH_IDLE;
        endcase
        word.addressed_to_me = slave_match;
        return made;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t next_word;
        if (!rst_n) begin
            own_addr    = OWN_ADDRESS_RESET;
            threshold   = BIT_THRESHOLD_RESET;
            frame_phase = PH_IDLE;
            restart_field();
            slave_match = 1'b0;
            payload_len = '0;
            bytes_done  = '0;
            expected_fields.delete();
            mismatches     = 0;
            words_pending  <= 0;
            mismatch_count <= 0;
        end
        else begin
            if (field_mon.valid && field_mon.ready) begin
                if (expected_fields.size() == 0) begin
                    $error("field word with none expected: kind %0d value %0h",
                           field_mon.field_kind, field_mon.field_value);
                    mismatches++;
                end
                else begin
                    want = expected_fields.pop_front();
                    if (field_mon.field_kind != want.field_kind) begin
                        $error("field_kind: expected %0d, got %0d",
                               want.field_kind, field_mon.field_kind);
                        mismatches++;
                    end
                    if (field_mon.field_value != want.field_value) begin
                        $error("field_value: expected %0h, got %0h",
                               want.field_value, field_mon.field_value);
                        mismatches++;
                    end
                    if (field_mon.byte_index != want.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               want.byte_index, field_mon.byte_index);
                        mismatches++;
                    end
                    if (field_mon.parity_bad != want.parity_bad) begin
                        $error("parity_bad: expected %0b, got %0b",
                               want.parity_bad, field_mon.parity_bad);
                        mismatches++;
                    end
                    if (field_mon.addressed_to_me != want.addressed_to_me) begin
                        $error("addressed_to_me: expected %0b, got %0b",
                               want.addressed_to_me, field_mon.addressed_to_me);
                        mismatches++;
                    end
                    if (field_mon.drive_ack != want.drive_ack) begin
                        $error("drive_ack: expected %0b, got %0b",
                               want.drive_ack, field_mon.drive_ack);
                        mismatches++;
                    end
                    if (field_mon.frame_last != want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b",
                               want.frame_last, field_mon.frame_last);
                        mismatches++;
                    end
                end
            end
            if (write_en) begin
                if (write_index == REG_OWN_ADDRESS)
                    own_addr = write_data[ADDR_W-1:0];
                else if (write_index == REG_BIT_THRESHOLD)
                    threshold = write_data[THRESH_W-1:0];
            end
            if (pulse_mon.valid && pulse_mon.ready) begin
                if (decode_pulse(pulse_mon.pulse_ticks, pulse_mon.begin_frame, next_word))
                    expected_fields.push_back(next_word);
            end
            words_pending  <= expected_fields.size();
            mismatch_count <= mismatches;
        end
    end

endmodule

>>> sim/tb_avc_lan_frame_receiver_unit.sv
// Testbench top for the AVC-LAN frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_avc_lan_frame_receiver_unit;
    import avlr_pkg::*;

    // Generous bound on the whole run; a healthy run ends far below it
    localparam int unsigned CYCLE_LIMIT = 4000000;
    // Random pulses per configuration setting, and how many settings to visit
    localparam int          ITEMS_PER_SETTING = 250;
    localparam int          SETTING_COUNT     = 8;
    // Cycles the receiver refuses words during a forced hold-off
    localparam int          HOLD_CYCLES       = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   write_en;
    logic [CFG_INDEX_W-1:0] write_index;
    logic [CFG_DATA_W-1:0]  write_data;

    int unsigned            words_pending;
    int unsigned            mismatch_count;
    int unsigned            cycle_count = 0;

    // Stimulus bookkeeping
    int                     cur_own     = OWN_ADDRESS_RESET;
    int                     cur_thr     = BIT_THRESHOLD_RESET;
    bit                     cut         = 1'b0;  // frame truncated or aborted: send no more bits
    int                     bits_left   = -1;    // bits before truncation, -1 for a whole frame
    bit                     tx_steady   = 1'b0;  // sender offers back to back, no gaps
    int                     phase_items = 0;
    int                     hold_asked  = 0;     // bumped by the stimulus to request a hold-off

    avlr_pulse_if pulse_ch ();
    avlr_field_if field_ch ();

    avc_lan_frame_receiver_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_in    (pulse_ch),
        .field_out   (field_ch),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data)
    );

    avlr_field_monitor u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .pulse_mon      (pulse_ch),
        .field_mon      (field_ch),
        .write_en       (write_en),
        .write_index    (write_index),
        .write_data     (write_data),
        .words_pending  (words_pending),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Pulse width that decodes as the given bit under the current threshold.
    // Lean on the threshold edge and on the extremes of the tick range.
    function automatic logic [TICK_WIDTH_DEFAULT-1:0] ticks_for(input logic b);
        int r;
        r = $urandom_range(7, 0);
        if (b && cur_thr > 0)
        begin
            if (r == 0)
                return TICK_WIDTH_DEFAULT'(cur_thr - 1);
            if (r == 1)
                return '0;
            return TICK_WIDTH_DEFAULT'($urandom_range(cur_thr - 1, 0));
        end
        // With a zero threshold no width can decode as one
        if (b)
            return TICK_WIDTH_DEFAULT'($urandom_range(255, 0));
        if (r == 0)
            return TICK_WIDTH_DEFAULT'(cur_thr);
        if (r == 1)
            return '1;
        return TICK_WIDTH_DEFAULT'($urandom_range(255, cur_thr));
    endfunction

    // Addresses with the all-zero and all-one corners weighted up
    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return ADDR_W'($urandom);
    endfunction

    // Offer one pulse word and hold it until the block takes it. Keep valid high
    // when no gap follows, so the next word can replace this one in the same step.
    task automatic send_pulse(input logic [TICK_WIDTH_DEFAULT-1:0] ticks, input logic start);
        int gap;
        pulse_ch.valid       <= 1'b1;
        pulse_ch.pulse_ticks <= ticks;
        pulse_ch.begin_frame <= start;
        @(posedge clk);
        while (!pulse_ch.ready)
            @(posedge clk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One frame bit; drop it once the frame has been cut short
    task automatic send_bit(input logic b);
        if (cut)
            return;
        if (bits_left == 0)
        begin
            cut = 1'b1;
            return;
        end
        if (bits_left > 0)
            bits_left--;
        send_pulse(ticks_for(b), 1'b0);
        phase_items++;
    endtask

    // Field bits MSB first, then the parity bit; flip it to force an abort
    task automatic send_field(input logic [VALUE_W-1:0] value, input int width, input bit flip);
        logic par;
        par = 1'b0;
        for (int i = width - 1; i >= 0; i--)
        begin
            send_bit(value[i]);
            par ^= value[i];
        end
        send_bit(par ^ flip);
        if (flip)
            cut = 1'b1;
    endtask

    // A full frame with random content. Now and then inject a parity error into
    // one field, or truncate the frame so the next start bit drops it.
    task automatic send_frame();
        logic [ADDR_W-1:0]  master;
        logic [ADDR_W-1:0]  slave;
        logic [3:0]         ctrl;
        logic [INDEX_W-1:0] len;
        logic [INDEX_W-1:0] data;
        int                 r;
        int                 bad_at;
        int                 bad_byte;
        int                 nbytes;
        master = pick_addr();
        slave  = ($urandom_range(1, 0) == 1) ? ADDR_W'(cur_own) : pick_addr();
        ctrl   = 4'($urandom);
        r      = $urandom_range(9, 0);
        if (r < 3)
            len = '0;
        else if (r < 8)
            len = INDEX_W'($urandom_range(4, 1));
        else if (r == 8)
            len = INDEX_W'($urandom_range(16, 5));
        else
            len = '1;
        // A maximal payload is far too long to send; cut it after a few bytes
        nbytes    = (len == '1) ? $urandom_range(6, 1) : int'(len);
        bad_byte  = (nbytes > 0) ? $urandom_range(nbytes - 1, 0) : 0;
        bad_at    = ($urandom_range(5, 0) == 0) ? $urandom_range(5, 1) : 0;
        bits_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 1) : -1;
        tx_steady = ($urandom_range(4, 0) == 0);
        cut       = 1'b0;

        send_pulse(TICK_WIDTH_DEFAULT'($urandom), 1'b1);
        phase_items++;
        send_bit(1'($urandom_range(1, 0)));              // broadcast bit
        send_field(master, ADDR_W, bad_at == 1);
        send_field(slave, ADDR_W, bad_at == 2);
        send_bit(1'($urandom_range(1, 0)));              // ack slot
        send_field(ctrl, 4, bad_at == 3);
        send_bit(1'($urandom_range(1, 0)));
        send_field(len, INDEX_W, bad_at == 4);
        send_bit(1'($urandom_range(1, 0)));
        for (int i = 0; i < nbytes; i++)
        begin
            r    = $urandom_range(7, 0);
            data = (r == 0) ? '0 : (r == 1) ? '1 : INDEX_W'($urandom);
            send_field(data, INDEX_W, bad_at == 5 && i == bad_byte);
            send_bit(1'($urandom_range(1, 0)));
        end
    endtask

    // Stray pulses between frames; the block drops them when idle
    task automatic send_noise();
        repeat ($urandom_range(3, 1))
            send_pulse(TICK_WIDTH_DEFAULT'($urandom), 1'b0);
    endtask

    // Drop valid and wait until every expected word has come out, so the block is
    // idle for a register write
    task automatic settle();
        pulse_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input int own, input int thr);
        write_en    <= 1'b1;
        write_index <= REG_OWN_ADDRESS;
        write_data  <= CFG_DATA_W'(own);
        @(posedge clk);
        write_index <= REG_BIT_THRESHOLD;
        write_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        write_en <= 1'b0;
        cur_own = own;
        cur_thr = thr;
    endtask

    // Receiver side: runs of ready with random gaps, plus a long hold-off on
    // request so the two-entry output buffer fills and pulse_in stalls
    initial
    begin
        int rx_run;
        int rx_idle;
        int hold_left;
        int hold_served;
        rx_run      = 0;
        rx_idle     = 0;
        hold_left   = 0;
        hold_served = 0;
        field_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                field_ch.ready <= 1'b0;
            end
            else if (rx_idle > 0)
            begin
                rx_idle--;
                field_ch.ready <= 1'b0;
            end
            else if (rx_run > 0)
            begin
                rx_run--;
                field_ch.ready <= 1'b1;
            end
            else
            begin
                rx_run  = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                     : $urandom_range(12, 0);
                rx_idle = pick_gap();
                field_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("avc_lan_frame_receiver_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        pulse_ch.valid       <= 1'b0;
        pulse_ch.pulse_ticks <= '0;
        pulse_ch.begin_frame <= 1'b0;
        write_en             <= 1'b0;
        write_index          <= REG_OWN_ADDRESS;
        write_data           <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (own address 0, threshold 26)
        send_pulse(8'd0, 1'b0);            // idle pulses: ignored
        send_pulse(8'd255, 1'b0);
        send_pulse(8'd255, 1'b1);          // start bit: width not decoded
        send_pulse(8'd25, 1'b0);           // broadcast, just below threshold: one
        send_pulse(8'd26, 1'b0);           // master bits, at threshold: zero
        send_pulse(8'd0, 1'b0);
        send_pulse(8'd128, 1'b0);
        send_pulse(8'd0, 1'b1);            // restart in mid field: frame dropped
        send_pulse(8'd26, 1'b0);           // broadcast zero
        send_field('1, ADDR_W, 1'b1);      // all-ones master with bad parity: abort
        send_pulse(8'd7, 1'b0);            // idle again after the abort

        // Random part: sweep settings, extremes first; hold off the receiver twice
        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            settle();
            case (p)
                0:       program_regs(12'hFFF, 255);
                1:       program_regs(0, 0);
                2:       program_regs(0, 1);
                3:       program_regs($urandom_range(4095, 0), BIT_THRESHOLD_RESET);
                4:       program_regs(12'h555, 128);
                default: program_regs($urandom_range(4095, 0), $urandom_range(254, 2));
            endcase
            if (p == 2 || p == 5)
                hold_asked <= hold_asked + 1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_SETTING)
            begin
                send_frame();
                if ($urandom_range(5, 0) == 0)
                    send_noise();
            end
        end

        // Drain and let the last word clear the pipeline before the verdict
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("avc_lan_frame_receiver_unit regression: pass");
        else
            $display("avc_lan_frame_receiver_unit regression: fail");
        $finish;
    end

endmodule
